/* hdl/pfx_pkg.sv */
`timescale 1ns / 1ps

package pfx_pkg;

	localparam int WORD_W = 32;
	localparam int STEP_W = 5;

	localparam logic [WORD_W-1:0] ALL_ONES = '1;

	// character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FLUSH,
		S_POP_R,
		S_POP_L,
		S_EXEC,
		S_DIV,
		S_FIX,
		S_PUSH,
		S_POP_F,
		S_REPORT
	} state_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
	endfunction

endpackage

/* hdl/pfx_if.sv */
`timescale 1ns / 1ps

// character channel
interface pfx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_expression;

	modport source (output valid, output char_code, output end_of_expression, input ready);
	modport sink   (input valid, input char_code, input end_of_expression, output ready);
endinterface

// result channel
interface pfx_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [1:0]         status;

	modport source (output valid, output value, output status, input ready);
	modport sink   (input valid, input value, input status, output ready);
endinterface

/* hdl/pfx_ram.sv */
`timescale 1ns / 1ps

// simple dual-port RAM, one write and one registered read port
module pfx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/postfix_expression_evaluator_top.sv */
`timescale 1ns / 1ps
// Postfix evaluator: one character per transfer, operand stack in a RAM.
// The 32-step restoring divider on the shared adder makes '/' with a nonzero
// divisor the worst case. The end flag adds a final pop and a report, plus any
// wait for the result register to drain. arst_n clears stack count, number run,
// status and result valid; stack RAM is not cleared.
module postfix_expression_evaluator_top #(
	parameter int STACK_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	pfx_in_if.sink      expr,
	pfx_out_if.source   result
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int W  = pfx_pkg::WORD_W;

	localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

	// control state
	pfx_pkg::state_t  state_q, state_d;
	pfx_pkg::status_t err_q;
	logic [CW-1:0]    cnt_q;
	logic             innum_q;
	logic             out_valid_q;

	// datapath registers
	logic [W-1:0]     acc_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic             hit_q;       // last pop found an entry
	logic [W-1:0]     rhs_q;
	logic [W-1:0]     res_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;       // dividend shifts out, quotient shifts in
	logic [W-1:0]     mb_q;
	logic             neg_q;
	logic [pfx_pkg::STEP_W-1:0] step_q;
	logic [W-1:0]     out_value_q;
	logic [1:0]       out_status_q;

	// control outputs
	logic             expr_rdy;
	logic             push_req, pop_req;
	logic [W-1:0]     push_data;
	logic             err_set;
	pfx_pkg::status_t err_code;
	logic             out_load;

	// shared adder / subtractor
	logic [W:0]       alu_a, alu_b;
	logic             alu_sub;
	logic [W+1:0]     alu_y;

	logic             accept, full, empty, push_ok, pop_ok;
	logic [CW-1:0]    cnt_dec;
	logic [W-1:0]     rd_data, lhs_w, mul_lo, acc_next, lhs_mag, rhs_mag;
	logic [W:0]       div_sh;
	logic             div_ge;

	assign accept  = expr.valid && expr_rdy;
	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign push_ok = push_req && !full;
	assign pop_ok  = pop_req && !empty;
	assign cnt_dec = cnt_q - CW'(1);

	assign alu_y = {1'b0, alu_a} + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b})
		+ (W+2)'(alu_sub);

	// empty pop reads as all ones
	assign lhs_w  = hit_q ? rd_data : pfx_pkg::ALL_ONES;
	assign mul_lo = lhs_w * rhs_q;

	// acc * 10 + digit
	assign acc_next = {acc_q[W-4:0], 3'b000} + {acc_q[W-2:0], 1'b0}
		+ W'(expr.char_code - pfx_pkg::CH_ZERO);

	assign lhs_mag = lhs_w[W-1] ? (W'(0) - lhs_w) : lhs_w;
	assign rhs_mag = rhs_q[W-1] ? (W'(0) - rhs_q) : rhs_q;

	// restoring step: bring down next dividend bit, trial subtract
	assign div_sh = {rem_q, quo_q[W-1]};
	assign div_ge = !alu_y[W+1];

	pfx_ram #(
		.WIDTH (W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (push_ok),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (push_data),
		.rd_en   (pop_ok),
		.rd_addr (cnt_dec[AW-1:0]),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfx_pkg::S_IDLE: begin
				if (accept) begin
					if (pfx_pkg::is_digit(expr.char_code)) begin
						state_d = expr.end_of_expression ? pfx_pkg::S_FLUSH : pfx_pkg::S_IDLE;
					end else begin
						state_d = pfx_pkg::S_FLUSH;
					end
				end
			end
			pfx_pkg::S_FLUSH: begin
				if (pfx_pkg::is_op(char_q)) begin
					state_d = pfx_pkg::S_POP_R;
				end else begin
					state_d = last_q ? pfx_pkg::S_POP_F : pfx_pkg::S_IDLE;
				end
			end
			pfx_pkg::S_POP_R: state_d = pfx_pkg::S_POP_L;
			pfx_pkg::S_POP_L: state_d = pfx_pkg::S_EXEC;
			pfx_pkg::S_EXEC: begin
				if (char_q == pfx_pkg::CH_SLASH && rhs_q != '0) begin
					state_d = pfx_pkg::S_DIV;
				end else begin
					state_d = pfx_pkg::S_PUSH;
				end
			end
			pfx_pkg::S_DIV: begin
				if (step_q == '0) begin
					state_d = pfx_pkg::S_FIX;
				end
			end
			pfx_pkg::S_FIX:   state_d = pfx_pkg::S_PUSH;
			pfx_pkg::S_PUSH:  state_d = last_q ? pfx_pkg::S_POP_F : pfx_pkg::S_IDLE;
			pfx_pkg::S_POP_F: state_d = pfx_pkg::S_REPORT;
			pfx_pkg::S_REPORT: begin
				if (out_load) begin
					state_d = pfx_pkg::S_IDLE;
				end
			end
			default: state_d = pfx_pkg::S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		expr_rdy  = 1'b0;
		push_req  = 1'b0;
		push_data = acc_q;
		pop_req   = 1'b0;
		alu_a     = '0;
		alu_b     = '0;
		alu_sub   = 1'b0;
		err_set   = 1'b0;
		err_code  = pfx_pkg::ST_OK;
		out_load  = 1'b0;
		unique case (state_q)
			pfx_pkg::S_IDLE:  expr_rdy = 1'b1;
			pfx_pkg::S_FLUSH: begin
				push_req  = innum_q;
				push_data = acc_q;
			end
			pfx_pkg::S_POP_R, pfx_pkg::S_POP_L, pfx_pkg::S_POP_F: pop_req = 1'b1;
			pfx_pkg::S_EXEC: begin
				alu_a   = {1'b0, lhs_w};
				alu_b   = {1'b0, rhs_q};
				alu_sub = (char_q == pfx_pkg::CH_MINUS);
				if (char_q == pfx_pkg::CH_SLASH && rhs_q == '0) begin
					err_set  = 1'b1;
					err_code = pfx_pkg::ST_DIVZ;
				end
			end
			pfx_pkg::S_DIV: begin
				alu_a   = div_sh;
				alu_b   = {1'b0, mb_q};
				alu_sub = 1'b1;
			end
			pfx_pkg::S_FIX: begin
				// negate quotient when operand signs differ
				alu_a   = '0;
				alu_b   = {1'b0, quo_q};
				alu_sub = neg_q;
			end
			pfx_pkg::S_PUSH: begin
				push_req  = 1'b1;
				push_data = res_q;
			end
			pfx_pkg::S_REPORT: out_load = !out_valid_q || result.ready;
			default: ;
		endcase
		if (push_req && full) begin
			err_set  = 1'b1;
			err_code = pfx_pkg::ST_OVER;
		end
		if (pop_req && empty) begin
			err_set  = 1'b1;
			err_code = pfx_pkg::ST_UNDER;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfx_pkg::S_IDLE;
			err_q       <= pfx_pkg::ST_OK;
			cnt_q       <= '0;
			innum_q     <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			// first error since last report sticks
			if (out_load) begin
				err_q <= pfx_pkg::ST_OK;
			end else if (err_set && err_q == pfx_pkg::ST_OK) begin
				err_q <= err_code;
			end
			if (out_load) begin
				cnt_q <= '0;
			end else if (push_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop_ok) begin
				cnt_q <= cnt_dec;
			end
			if (accept && pfx_pkg::is_digit(expr.char_code)) begin
				acc_q   <= acc_next;
				innum_q <= 1'b1;
			end else if (state_q == pfx_pkg::S_FLUSH) begin
				acc_q   <= '0;
				innum_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= expr.char_code;
			last_q <= expr.end_of_expression;
		end
		if (pop_req) begin
			hit_q <= !empty;
		end
		if (state_q == pfx_pkg::S_POP_L) begin
			rhs_q <= lhs_w;
		end
		unique case (state_q)
			pfx_pkg::S_EXEC: begin
				priority if (char_q == pfx_pkg::CH_STAR) begin
					res_q <= mul_lo;
				end else if (char_q == pfx_pkg::CH_SLASH) begin
					res_q  <= '0;
					rem_q  <= '0;
					quo_q  <= lhs_mag;
					mb_q   <= rhs_mag;
					neg_q  <= lhs_w[W-1] ^ rhs_q[W-1];
					step_q <= '1;
				end else begin
					res_q <= alu_y[W-1:0];
				end
			end
			pfx_pkg::S_DIV: begin
				rem_q  <= div_ge ? alu_y[W-1:0] : div_sh[W-1:0];
				quo_q  <= {quo_q[W-2:0], div_ge};
				step_q <= step_q - pfx_pkg::STEP_W'(1);
			end
			pfx_pkg::S_FIX: res_q <= alu_y[W-1:0];
			default: ;
		endcase
		if (out_load) begin
			out_value_q  <= lhs_w;
			out_status_q <= err_q;
		end
	end

	assign expr.ready   = expr_rdy;
	assign result.valid = out_valid_q;
	assign result.value = out_value_q;
	assign result.status = out_status_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("stack count beyond depth");

	a_report_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (cnt_q == '0) && (err_q == pfx_pkg::ST_OK) && !innum_q)
		else $error("state not cleared after report");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfx_pkg::S_DIV |-> rem_q < mb_q)
		else $error("partial remainder not below divisor");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfx_pkg::S_DIV && step_q == '0) |=> state_q == pfx_pkg::S_FIX)
		else $error("divider did not finish after last step");
`endif

endmodule

/* tb/postfix_expression_evaluator_top_test.sv */
`timescale 1ns / 1ps

module postfix_expression_evaluator_top_test;

	localparam int STACK_DEPTH = 32;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// One character transfer as queued for the driver.
	// hold_for_drain: keep the channel quiet until every pending report is in.
	typedef struct packed {
		logic [7:0] code;
		logic       last;
		logic       hold_for_drain;
	} char_xfer_t;

	// What one end-of-expression transfer should report.
	typedef struct packed {
		logic [31:0]      value;
		pfx_pkg::status_t status;
	} report_t;

	// Shapes of generated expressions.
	typedef enum {
		SHAPE_NORMAL,   // well-formed but for a possible trailing operand, random length and content
		SHAPE_SLOPPY,   // stray operators, ops left off the end
		SHAPE_PILED     // all operands first: deep stack, may overflow
	} shape_t;

	logic clk = 1'b0;
	logic arst_n;

	pfx_in_if  expr_ch ();
	pfx_out_if result_ch ();

	postfix_expression_evaluator_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.expr   (expr_ch),
		.result (result_ch)
	);

	always #10 clk = ~clk;

	char_xfer_t char_stream[$];      // characters still to be sent
	report_t    pending_reports[$];  // reports owed by the block, oldest first
	int         chars_taken = 0;
	int         chars_planned = 0;
	int         faults = 0;
	bit         drain_pending = 1'b0;

	// Window of accepted characters where neither side idles.
	logic calm;
	assign calm = (chars_taken >= 550) && (chars_taken < 750);

	// ------------------------------------------------------------------
	// Evaluator shadow state
	// ------------------------------------------------------------------
	logic [31:0]      operand_mem [STACK_DEPTH];
	int unsigned      stack_fill = 0;
	logic [31:0]      digit_acc = '0;
	bit               in_digits = 1'b0;
	pfx_pkg::status_t first_err = pfx_pkg::ST_OK;

	// Status is sticky on the first error since the last report.
	function automatic void note_error(pfx_pkg::status_t code);
		if (first_err == pfx_pkg::ST_OK)
			first_err = code;
	endfunction

	// Full stack drops the word.
	function automatic void push_operand(logic [31:0] v);
		if (stack_fill >= STACK_DEPTH) begin
			note_error(pfx_pkg::ST_OVER);
		end else begin
			operand_mem[stack_fill] = v;
			stack_fill++;
		end
	endfunction

	// Empty stack gives all ones (-1).
	function automatic logic [31:0] pop_operand();
		if (stack_fill == 0) begin
			note_error(pfx_pkg::ST_UNDER);
			return pfx_pkg::ALL_ONES;
		end
		stack_fill--;
		return operand_mem[stack_fill];
	endfunction

	// Truncating signed divide done on magnitudes, so MIN / -1 wraps to MIN.
	function automatic logic [31:0] signed_quotient(logic [31:0] lhs, logic [31:0] rhs);
		logic [31:0] mag_l;
		logic [31:0] mag_r;
		logic [31:0] q;
		if (rhs == '0) begin
			note_error(pfx_pkg::ST_DIVZ);
			return '0;
		end
		mag_l = lhs[31] ? 32'd0 - lhs : lhs;
		mag_r = rhs[31] ? 32'd0 - rhs : rhs;
		q = mag_l / mag_r;
		return (lhs[31] ^ rhs[31]) ? 32'd0 - q : q;
	endfunction

	function automatic void flush_digits();
		if (in_digits) begin
			push_operand(digit_acc);
			digit_acc = '0;
			in_digits = 1'b0;
		end
	endfunction

	// Advance the shadow state by one accepted character; on the end flag
	// queue the report and clear everything for the next expression.
	function automatic void evaluate_char(logic [7:0] c, logic last);
		logic [31:0] rhs;
		logic [31:0] lhs;
		logic [31:0] res;
		report_t     rep;
		if (c >= pfx_pkg::CH_ZERO && c <= pfx_pkg::CH_NINE) begin
			digit_acc = digit_acc * 10 + 32'(c - pfx_pkg::CH_ZERO);
			in_digits = 1'b1;
		end else begin
			flush_digits();
			if (pfx_pkg::is_op(c)) begin
				rhs = pop_operand();
				lhs = pop_operand();
				case (c)
					pfx_pkg::CH_PLUS:  res = lhs + rhs;
					pfx_pkg::CH_MINUS: res = lhs - rhs;
					pfx_pkg::CH_STAR:  res = lhs * rhs;
					default:           res = signed_quotient(lhs, rhs);
				endcase
				push_operand(res);
			end
		end
		if (last) begin
			flush_digits();
			rep.value = pop_operand();
			rep.status = first_err;
			pending_reports.push_back(rep);
			stack_fill = 0;
			digit_acc = '0;
			in_digits = 1'b0;
			first_err = pfx_pkg::ST_OK;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	function automatic void add_char(logic [7:0] code, logic last);
		char_xfer_t x;
		x.code = code;
		x.last = last;
		x.hold_for_drain = drain_pending;
		drain_pending = 1'b0;
		char_stream.push_back(x);
	endfunction

	function automatic void mark_end();
		char_stream[char_stream.size() - 1].last = 1'b1;
	endfunction

	function automatic void add_digit_string(string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i], 1'b0);
	endfunction

	function automatic void add_number(logic [31:0] v);
		add_digit_string($sformatf("%0d", v));
	endfunction

	// Long digit run, may wrap past 32 bits
	function automatic void add_long_run(int unsigned n);
		repeat (n)
			add_char(pfx_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
	endfunction

	function automatic void add_random_number();
		case ($urandom_range(0, 9))
			0, 1:    add_number($urandom_range(0, 9));
			2:       add_number('0);
			3, 4:    add_number($urandom_range(0, 999));
			5:       add_number($urandom_range(0, 99999));
			6, 7:    add_number($urandom());
			8: begin
				case ($urandom_range(0, 2))
					0:       add_number(32'h7FFF_FFFF);
					1:       add_number(32'h8000_0000);
					default: add_number(32'hFFFF_FFFF);
				endcase
			end
			default: add_long_run($urandom_range(10, 14));
		endcase
	endfunction

	// Separator: mostly a space, else any byte that is neither digit nor operator.
	function automatic logic [7:0] random_gap();
		logic [7:0] c;
		if ($urandom_range(0, 3) != 0)
			return CH_SPACE;
		do
			c = 8'($urandom_range(0, 255));
		while (pfx_pkg::is_digit(c) || pfx_pkg::is_op(c));
		return c;
	endfunction

	function automatic logic [7:0] random_op();
		case ($urandom_range(0, 3))
			0:       return pfx_pkg::CH_PLUS;
			1:       return pfx_pkg::CH_MINUS;
			2:       return pfx_pkg::CH_STAR;
			default: return pfx_pkg::CH_SLASH;
		endcase
	endfunction

	// Depth tracking only steers the generator; an op on a short stack
	// still leaves one word behind.
	function automatic void gen_expression(shape_t shape);
		int unsigned left;
		int unsigned depth;
		bit          after_num;
		left = (shape == SHAPE_PILED) ? $urandom_range(20, 40) : $urandom_range(1, 8);
		depth = 0;
		after_num = 1'b0;
		while (left > 0 || depth > 1) begin
			if (left > 0 && (shape == SHAPE_PILED || depth < 2 || $urandom_range(0, 2) != 0)) begin
				if (after_num || $urandom_range(0, 3) == 0)
					add_char(random_gap(), 1'b0);
				add_random_number();
				depth++;
				left--;
				after_num = 1'b1;
			end else begin
				if ($urandom_range(0, 3) == 0)
					add_char(random_gap(), 1'b0);
				add_char(random_op(), 1'b0);
				depth = (depth < 2) ? 1 : depth - 1;
				after_num = 1'b0;
			end
			if (shape == SHAPE_SLOPPY && $urandom_range(0, 7) == 0) begin
				add_char(random_op(), 1'b0);
				depth = (depth < 2) ? 1 : depth - 1;
				after_num = 1'b0;
			end
			if (shape != SHAPE_NORMAL && left == 0 && $urandom_range(0, 3) == 0)
				break;
		end
		// how the expression closes: on a separator, on a trailing operand
		// still in the digit run, or on its own last character
		case ($urandom_range(0, 3))
			0: add_char(random_gap(), 1'b1);
			1: begin
				if (after_num)
					add_char(random_gap(), 1'b0);
				add_random_number();
				mark_end();
			end
			default: mark_end();
		endcase
	endfunction

	// Raw bytes, end flag anywhere
	function automatic void gen_noise();
		repeat ($urandom_range(1, 8))
			add_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
		mark_end();
	endfunction

	// ------------------------------------------------------------------
	// Driver: one character transfer at a time from char_stream
	// ------------------------------------------------------------------
	always @(posedge clk) begin : feed_chars
		char_xfer_t nxt;
		bit         hold;
		if (!arst_n) begin
			expr_ch.valid <= 1'b0;
			expr_ch.char_code <= '0;
			expr_ch.end_of_expression <= 1'b0;
		end else begin
			if (expr_ch.valid && expr_ch.ready) begin
				evaluate_char(expr_ch.char_code, expr_ch.end_of_expression);
				chars_taken++;
			end
			// valid stays up until the transfer; new choice only when free
			if (!expr_ch.valid || expr_ch.ready) begin
				hold = (char_stream.size() == 0) || (!calm && $urandom_range(0, 99) < 22);
				if (!hold && char_stream[0].hold_for_drain && pending_reports.size() != 0)
					hold = 1'b1;
				if (hold) begin
					expr_ch.valid <= 1'b0;
				end else begin
					nxt = char_stream.pop_front();
					expr_ch.valid <= 1'b1;
					expr_ch.char_code <= nxt.code;
					expr_ch.end_of_expression <= nxt.last;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every result transfer against the oldest pending report
	// ------------------------------------------------------------------
	function automatic void note_fault(string msg);
		faults++;
		if (faults <= 10)
			$display("%s", msg);
	endfunction

	always @(posedge clk) begin : check_results
		report_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (pending_reports.size() == 0) begin
					note_fault($sformatf("unexpected result: value %0d status %0d",
						result_ch.value, result_ch.status));
				end else begin
					want = pending_reports.pop_front();
					if (result_ch.value !== want.value)
						note_fault($sformatf("value mismatch: expected %0d, got %0d",
							$signed(want.value), result_ch.value));
					if (result_ch.status !== want.status)
						note_fault($sformatf("status mismatch: expected %0d, got %0d",
							want.status, result_ch.status));
				end
			end
			result_ch.ready <= calm || ($urandom_range(0, 99) >= 22);
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin : run_test
		int directed_len;
		int next_drain;
		int pick;

		arst_n = 1'b0;
		expr_ch.valid = 1'b0;
		expr_ch.char_code = '0;
		expr_ch.end_of_expression = 1'b0;
		result_ch.ready = 1'b0;

		// + and *, NUL as separator, pending digit run closed by the end flag
		add_number(4);
		add_char(8'h00, 1'b0);
		add_number(3);
		add_char(pfx_pkg::CH_STAR, 1'b0);
		add_number(5);
		add_char(pfx_pkg::CH_PLUS, 1'b0);
		add_number(2);
		mark_end();
		// subtraction to a negative, divide truncates toward zero: -7 / 2
		add_number(0);
		add_char(CH_SPACE, 1'b0);
		add_number(7);
		add_char(pfx_pkg::CH_MINUS, 1'b0);
		add_number(2);
		add_char(pfx_pkg::CH_SLASH, 1'b1);
		// nothing on the stack: -1 with underflow, top code value
		add_char(8'hFF, 1'b1);
		// underflow first, then divide by zero: status keeps underflow
		add_number(9);
		add_char(pfx_pkg::CH_PLUS, 1'b0);
		add_number(0);
		add_char(pfx_pkg::CH_SLASH, 1'b1);
		// plain divide by zero
		add_number(5);
		add_char(CH_SPACE, 1'b0);
		add_number(0);
		add_char(pfx_pkg::CH_SLASH, 1'b1);
		// digit run wraps to the most negative word, then divided by -1
		add_digit_string("6442450944");
		add_char(CH_SPACE, 1'b0);
		add_number(0);
		add_char(CH_SPACE, 1'b0);
		add_number(1);
		add_char(pfx_pkg::CH_MINUS, 1'b0);
		add_char(pfx_pkg::CH_SLASH, 1'b1);
		directed_len = char_stream.size();

		// random part opens with a piled stack that may overflow
		gen_expression(SHAPE_PILED);
		next_drain = directed_len + 300;
		while (char_stream.size() < 1050) begin
			if (char_stream.size() >= next_drain) begin
				drain_pending = 1'b1;
				next_drain += 400;
			end
			pick = $urandom_range(0, 99);
			if (pick < 75)
				gen_expression(SHAPE_NORMAL);
			else if (pick < 87)
				gen_expression(SHAPE_SLOPPY);
			else if (pick < 92)
				gen_expression(SHAPE_PILED);
			else
				gen_noise();
		end
		chars_planned = char_stream.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// every character taken and every report back
		while (chars_taken < chars_planned || pending_reports.size() != 0)
			@(posedge clk);
		// room for a stray extra result
		repeat (60) @(posedge clk);

		if (faults == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Hang guard, far beyond the slowest legal run
	initial begin : watchdog
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

/* postfix_expression_evaluator_top.f */
hdl/pfx_pkg.sv
hdl/pfx_if.sv
hdl/pfx_ram.sv
hdl/postfix_expression_evaluator_top.sv
tb/postfix_expression_evaluator_top_test.sv
